/* design/gmmd_pkg.sv */
// package for the grouped maximum manhattan distance unit
// holds the payload structs and shared constants, no dependencies
package gmmd_pkg;

  localparam int INDEX_BITS_DEF = 16;
  localparam int VALUE_BITS_DEF = 32;
  localparam int MASK_COUNT     = 8;
  localparam int OUT_BITS       = 34;

  typedef struct packed {
    logic        [15:0] row_index;
    logic signed [31:0] first_value;
    logic signed [31:0] second_value;
    logic               group_last;
    logic               set_last;
  } gmmd_in_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] group_diameter;
    logic [OUT_BITS-1:0] best_so_far;
    logic                set_done;
  } gmmd_out_t;

endpackage

/* design/grouped_max_manhattan_distance_unit.sv */
// Grouped maximum Manhattan distance over a stream of 3-D points. Takes one point per
// cycle; throughput is one word per clock as long as results are taken, and a group's
// result passes the sum, extreme, spread and diameter registers to the output register.
// The 8-mask extreme registers and the set best are the only loops (one
// three-input add per mask ahead of the extremes, one compare-and-select inside each),
// so nothing limits the rate below one point per cycle. in_stall rises only when a
// result is ready to leave and the output register still holds an untaken result.
// depends on gmmd_pkg

module grouped_max_manhattan_distance_unit #(
  parameter int INDEX_BITS = gmmd_pkg::INDEX_BITS_DEF,
  parameter int VALUE_BITS = gmmd_pkg::VALUE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  gmmd_pkg::gmmd_in_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output gmmd_pkg::gmmd_out_t out_data
);
  import gmmd_pkg::*;

  localparam int OPND_W = (INDEX_BITS + 1 > VALUE_BITS) ? INDEX_BITS + 1 : VALUE_BITS;
  localparam int SUM_W  = OPND_W + 2;
  localparam int DIFF_W = SUM_W + 1;
  localparam int WIDE_W = (DIFF_W > OUT_BITS) ? DIFF_W : OUT_BITS;

  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic [DIFF_W-1:0]       diff_t;

  logic adv;

  // stage 1: input register
  logic     s1_v_r;
  gmmd_in_t s1_pt_r;

  // stage 2: mask sums
  logic s2_v_r, s2_gend_r, s2_send_r;
  sum_t s2_sum_r [MASK_COUNT];
  sum_t sum_nxt  [MASK_COUNT];

  // stage 3: running extremes of the open group
  logic s3_v_r, s3_send_r, empty_r;
  sum_t max_r [MASK_COUNT];
  sum_t min_r [MASK_COUNT];
  sum_t max_nxt [MASK_COUNT];
  sum_t min_nxt [MASK_COUNT];

  // stage 4: spread per mask
  logic  s4_v_r, s4_send_r;
  diff_t s4_diff_r [MASK_COUNT];

  // stage 5: diameter
  logic                s5_v_r, s5_send_r;
  logic [OUT_BITS-1:0] s5_diam_r;
  diff_t               lvl1 [4];
  diff_t               lvl2 [2];
  diff_t               lvl3;
  logic [WIDE_W-1:0]   diam_wide;
  logic [OUT_BITS-1:0] diam_sat;

  // output stage
  logic                out_valid_r;
  gmmd_out_t           out_data_r;
  logic [OUT_BITS-1:0] best_r;
  logic [OUT_BITS-1:0] best_nxt;

  logic [INDEX_BITS-1:0]        row_lo;
  logic signed [VALUE_BITS-1:0] a_lo, b_lo;
  sum_t                         r_ext, a_ext, b_ext;

  // only a finished result blocked by a full output register holds the pipe
  assign adv      = !(s5_v_r && out_valid_r && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid;
    end
    if (adv && in_valid) begin
      s1_pt_r <= in_data;
    end
  end

  always_comb begin
    row_lo = INDEX_BITS'(s1_pt_r.row_index);
    a_lo   = VALUE_BITS'(s1_pt_r.first_value);
    b_lo   = VALUE_BITS'(s1_pt_r.second_value);
    r_ext  = sum_t'({1'b0, row_lo});
    a_ext  = sum_t'(a_lo);
    b_ext  = sum_t'(b_lo);
    // bit 0 negates row, bit 1 the first value, bit 2 the second value
    for (int k = 0; k < MASK_COUNT; k++) begin
      sum_nxt[k] = (k[0] ? -r_ext : r_ext) + (k[1] ? -a_ext : a_ext)
                 + (k[2] ? -b_ext : b_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
    if (adv && s1_v_r) begin
      s2_sum_r  <= sum_nxt;
      s2_gend_r <= s1_pt_r.group_last || s1_pt_r.set_last;
      s2_send_r <= s1_pt_r.set_last;
    end
  end

  // first point of a group loads both extremes
  always_comb begin
    for (int k = 0; k < MASK_COUNT; k++) begin
      max_nxt[k] = (empty_r || s2_sum_r[k] > max_r[k]) ? s2_sum_r[k] : max_r[k];
      min_nxt[k] = (empty_r || s2_sum_r[k] < min_r[k]) ? s2_sum_r[k] : min_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r  <= 1'b0;
      empty_r <= 1'b1;
    end else if (adv) begin
      s3_v_r <= s2_v_r && s2_gend_r;
      if (s2_v_r) begin
        empty_r <= s2_gend_r;
      end
    end
    if (adv && s2_v_r) begin
      max_r     <= max_nxt;
      min_r     <= min_nxt;
      s3_send_r <= s2_send_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (adv) begin
      s4_v_r <= s3_v_r;
    end
    if (adv && s3_v_r) begin
      for (int k = 0; k < MASK_COUNT; k++) begin
        s4_diff_r[k] <= diff_t'(DIFF_W'(max_r[k]) - DIFF_W'(min_r[k]));
      end
      s4_send_r <= s3_send_r;
    end
  end

  // three-level max tree, then clamp to the result width
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      lvl1[i] = (s4_diff_r[2*i] > s4_diff_r[2*i+1]) ? s4_diff_r[2*i] : s4_diff_r[2*i+1];
    end
    for (int i = 0; i < 2; i++) begin
      lvl2[i] = (lvl1[2*i] > lvl1[2*i+1]) ? lvl1[2*i] : lvl1[2*i+1];
    end
    lvl3      = (lvl2[0] > lvl2[1]) ? lvl2[0] : lvl2[1];
    diam_wide = WIDE_W'(lvl3);
    diam_sat  = (diam_wide > WIDE_W'({OUT_BITS{1'b1}})) ? {OUT_BITS{1'b1}}
                                                       : diam_wide[OUT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (adv) begin
      s5_v_r <= s4_v_r;
    end
    if (adv && s4_v_r) begin
      s5_diam_r <= diam_sat;
      s5_send_r <= s4_send_r;
    end
  end

  assign best_nxt = (s5_diam_r > best_r) ? s5_diam_r : best_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      best_r      <= '0;
    end else if (adv && s5_v_r) begin
      out_valid_r <= 1'b1;
      best_r      <= s5_send_r ? '0 : best_nxt;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (adv && s5_v_r) begin
      out_data_r.group_diameter <= s5_diam_r;
      out_data_r.best_so_far    <= best_nxt;
      out_data_r.set_done       <= s5_send_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* design/gmmd_checker.sv */
// port-level checks for the grouped maximum manhattan distance unit
// depends on gmmd_pkg, bound to grouped_max_manhattan_distance_unit below
module gmmd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input gmmd_pkg::gmmd_in_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input gmmd_pkg::gmmd_out_t out_data
);
  import gmmd_pkg::*;

  logic                first_of_set_r;
  logic [OUT_BITS-1:0] last_best_r;
  logic                out_take;

  assign out_take = out_valid && !out_stall;

  // tracks where a set starts and the best value last delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_of_set_r <= 1'b1;
      last_best_r    <= '0;
    end else if (out_take) begin
      first_of_set_r <= out_data.set_done;
      last_best_r    <= out_data.best_so_far;
    end
  end

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input word changed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  a_best_covers: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.best_so_far >= out_data.group_diameter)
    else $error("best below group diameter");

  a_set_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && first_of_set_r |-> out_data.best_so_far == out_data.group_diameter)
    else $error("best not restarted at set start");

  a_best_grows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !first_of_set_r |-> out_data.best_so_far >= last_best_r)
    else $error("best dropped within a set");

endmodule

bind grouped_max_manhattan_distance_unit gmmd_checker u_gmmd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
